FILE: hdl/tras_pkg.sv
// ----------------------------------------------------------------------------
// Typing-rate animation sequencer package
// Shared types, register map and constants of the animation sequencer.
// ----------------------------------------------------------------------------
package tras_pkg;

	localparam int FRAME_W          = 4;
	localparam int RATE_W           = 10;
	localparam int ELAPSED_W        = 10;
	localparam int TIMER_W          = 16;
	localparam int DELAY_W          = 8;
	localparam int IDLE_FRAME_COUNT = 5;
	localparam int TAP_FRAME_COUNT  = 2;

	localparam int DELAY_BASE = 300;
	localparam int DELAY_MIN  = 80;
	localparam int DELAY_MAX  = 250;

	// Rates at or below this give the maximum delay; at or above the next give the minimum.
	localparam logic [RATE_W-1:0] RATE_SLOW_LIMIT = RATE_W'((DELAY_BASE - DELAY_MAX) / 2);
	localparam logic [RATE_W-1:0] RATE_FAST_LIMIT = RATE_W'((DELAY_BASE - DELAY_MIN) / 2);

	localparam logic [FRAME_W:0] IDLE_WRAP = (FRAME_W+1)'(IDLE_FRAME_COUNT);
	localparam logic [FRAME_W:0] TAP_WRAP  = (FRAME_W+1)'(TAP_FRAME_COUNT);

	localparam logic [RATE_W-1:0]  TAP_THRESHOLD_RST  = RATE_W'(20);
	localparam logic [RATE_W-1:0]  PREP_THRESHOLD_RST = RATE_W'(10);
	localparam logic [TIMER_W-1:0] IDLE_TIMEOUT_RST   = TIMER_W'(500);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_TAP_THRESHOLD  = 2'd0,
		REG_PREP_THRESHOLD = 2'd1,
		REG_IDLE_TIMEOUT   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_PREP = 2'd1,
		MODE_TAP  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [RATE_W-1:0]  tap_threshold;
		logic [RATE_W-1:0]  prep_threshold;
		logic [TIMER_W-1:0] idle_timeout;
	} cfg_t;

	function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
			input logic [ELAPSED_W-1:0] b);
		logic [TIMER_W:0] sum;
		sum = {1'b0, a} + (TIMER_W+1)'(b);
		return sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
	endfunction

	function automatic logic [FRAME_W-1:0] frame_step(input logic [FRAME_W-1:0] f,
			input logic [FRAME_W:0] wrap);
		logic [FRAME_W:0] nxt;
		nxt = {1'b0, f} + (FRAME_W+1)'(1);
		return (nxt >= wrap) ? '0 : nxt[FRAME_W-1:0];
	endfunction

endpackage

FILE: hdl/tras_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file holding the mode thresholds and the idle timeout.
// ----------------------------------------------------------------------------
module tras_regs import tras_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_threshold  <= TAP_THRESHOLD_RST;
			cfg_q.prep_threshold <= PREP_THRESHOLD_RST;
			cfg_q.idle_timeout   <= IDLE_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_TAP_THRESHOLD:  cfg_q.tap_threshold  <= pwdata[RATE_W-1:0];
				REG_PREP_THRESHOLD: cfg_q.prep_threshold <= pwdata[RATE_W-1:0];
				REG_IDLE_TIMEOUT:   cfg_q.idle_timeout   <= pwdata[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TAP_THRESHOLD:  prdata = PDATA_W'(cfg_q.tap_threshold);
			REG_PREP_THRESHOLD: prdata = PDATA_W'(cfg_q.prep_threshold);
			REG_IDLE_TIMEOUT:   prdata = PDATA_W'(cfg_q.idle_timeout);
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: hdl/typing_rate_animation_sequencer_top.sv
// ----------------------------------------------------------------------------
// Typing-rate animation sequencer
// Picks an animation mode from the typing rate and steps its frame counter.
// ----------------------------------------------------------------------------
// Usage:
// Each tick word carries delta_ms and typing_rate on tick_valid; the block
// holds tick_stall high when it cannot take a word. Each tick gives exactly
// one result word (mode, frame_index, frame_delay) on res_valid, held until
// res_stall is low.
// A tick is registered at the input, then evaluated combinationally against
// the mode, timers and frame counters and written to the result register;
// one tick is taken every cycle while res_stall is low or no result is waiting.
// When res_stall is high with a result waiting, one further tick is still
// taken into the input register; after that tick_stall rises.
// Reset clears the mode to idle, both timers and both frame counters, empties
// both pipeline registers and loads the register defaults (tap threshold 20,
// prep threshold 10, idle timeout 500). The user must write registers over
// APB only while no tick is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module typing_rate_animation_sequencer_top import tras_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 tick_valid,
	output logic                 tick_stall,
	input  logic [ELAPSED_W-1:0] delta_ms,
	input  logic [RATE_W-1:0]    typing_rate,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [1:0]           mode,
	output logic [FRAME_W-1:0]   frame_index,
	output logic [DELAY_W-1:0]   frame_delay
);

	cfg_t cfg;

	tras_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic                 valid_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic [RATE_W-1:0]    rate_s1;
	logic                 advance;
	logic                 take;

	mode_t                mode_q;
	logic [TIMER_W-1:0]   anim_q;
	logic [TIMER_W-1:0]   mode_elapsed_q;
	logic [FRAME_W-1:0]   idle_frame_q;
	logic [FRAME_W-1:0]   tap_frame_q;

	logic                 valid_s2;
	mode_t                mode_s2;
	logic [FRAME_W-1:0]   frame_s2;
	logic [DELAY_W-1:0]   delay_s2;

	mode_t                target;
	mode_t                mode_d;
	logic [DELAY_W-1:0]   delay;
	logic [TIMER_W-1:0]   anim_d;
	logic [TIMER_W-1:0]   mode_elapsed_d;
	logic [FRAME_W-1:0]   idle_frame_d;
	logic [FRAME_W-1:0]   tap_frame_d;
	logic [FRAME_W-1:0]   frame;
	logic [RATE_W:0]      twice_rate;
	logic [RATE_W:0]      lin_delay;

	assign advance    = !valid_s2 || !res_stall;
	assign tick_stall = valid_s1 && !advance;
	assign take       = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			elapsed_s1 <= delta_ms;
			rate_s1    <= typing_rate;
		end
	end

	// Delay is 300 minus twice the rate, clamped; only the middle band needs the subtract.
	assign twice_rate = {rate_s1, 1'b0};
	assign lin_delay  = (RATE_W+1)'(DELAY_BASE) - twice_rate;

	always_comb begin
		if (rate_s1 <= RATE_SLOW_LIMIT) begin
			delay = DELAY_W'(DELAY_MAX);
		end else if (rate_s1 >= RATE_FAST_LIMIT) begin
			delay = DELAY_W'(DELAY_MIN);
		end else begin
			delay = lin_delay[DELAY_W-1:0];
		end
	end

	always_comb begin
		if (rate_s1 >= cfg.tap_threshold) begin
			target = MODE_TAP;
		end else if (rate_s1 >= cfg.prep_threshold) begin
			target = MODE_PREP;
		end else begin
			target = MODE_IDLE;
		end

		anim_d         = sat_add(anim_q, elapsed_s1);
		mode_elapsed_d = sat_add(mode_elapsed_q, elapsed_s1);
		idle_frame_d   = idle_frame_q;
		tap_frame_d    = tap_frame_q;
		mode_d         = mode_q;

		if (target != mode_q) begin
			mode_d         = target;
			anim_d         = '0;
			mode_elapsed_d = '0;
			if (target == MODE_IDLE) begin
				idle_frame_d = '0;
			end else if (target == MODE_TAP) begin
				tap_frame_d = '0;
			end
		end

		unique case (mode_d)
			MODE_IDLE: begin
				if (mode_elapsed_d >= cfg.idle_timeout && anim_d >= TIMER_W'(delay)) begin
					anim_d       = '0;
					idle_frame_d = frame_step(idle_frame_d, IDLE_WRAP);
				end
				frame = idle_frame_d;
			end
			MODE_TAP: begin
				if (anim_d >= TIMER_W'(delay)) begin
					anim_d      = '0;
					tap_frame_d = frame_step(tap_frame_d, TAP_WRAP);
				end
				frame = tap_frame_d;
			end
			default: begin
				frame = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			anim_q         <= '0;
			mode_elapsed_q <= '0;
			idle_frame_q   <= '0;
			tap_frame_q    <= '0;
			valid_s2       <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				mode_q         <= mode_d;
				anim_q         <= anim_d;
				mode_elapsed_q <= mode_elapsed_d;
				idle_frame_q   <= idle_frame_d;
				tap_frame_q    <= tap_frame_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			mode_s2  <= mode_d;
			frame_s2 <= frame;
			delay_s2 <= delay;
		end
	end

	assign res_valid   = valid_s2;
	assign mode        = mode_s2;
	assign frame_index = frame_s2;
	assign frame_delay = delay_s2;

	a_prep_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && mode_s2 == MODE_PREP |-> frame_s2 == '0)
		else $error("prep result with nonzero frame");

	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> frame_delay >= DELAY_W'(DELAY_MIN) && frame_delay <= DELAY_W'(DELAY_MAX))
		else $error("frame delay out of range");

	a_tap_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		(FRAME_W+1)'(tap_frame_q) < TAP_WRAP && (FRAME_W+1)'(idle_frame_q) < IDLE_WRAP)
		else $error("frame counter beyond its frame count");

	a_switch_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && target != mode_q |=> anim_q == '0 && mode_elapsed_q == '0)
		else $error("mode change did not clear timers");

	a_result_mode_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 |=> res_valid && mode_s2 == mode_q)
		else $error("result mode differs from state");

endmodule
